### hw/rtl/spm_pkg.sv
// Types, codes and widths shared by the sparse polynomial multiplier.
// No dependencies.
`default_nettype none

package spm_pkg;

    localparam int COEF_W  = 16;
    localparam int EXP_W   = 15;
    localparam int PROD_W  = 32;
    localparam int PCOEF_W = 36;
    localparam int PEXP_W  = 16;

    typedef enum logic [1:0] {
        KIND_FIRST   = 2'd0,
        KIND_SECOND  = 2'd1,
        KIND_COMPUTE = 2'd2
    } kind_t;

    typedef struct packed {
        logic [EXP_W-1:0]  expo;
        logic [COEF_W-1:0] coef;
    } term_t;

    // One product store entry; a zero coefficient marks a cancelled term.
    typedef struct packed {
        logic [PEXP_W-1:0]  expo;
        logic [PCOEF_W-1:0] coef;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Add a product into a running coefficient, clamped to the 36-bit range.
    function automatic logic [PCOEF_W-1:0] sat_add(input logic [PCOEF_W-1:0] acc,
                                                   input logic [PROD_W-1:0]  prod);
        logic [PCOEF_W:0] sum;
        sum = {acc[PCOEF_W-1], acc}
            + {{(PCOEF_W+1-PROD_W){prod[PROD_W-1]}}, prod};
        if (sum[PCOEF_W] != sum[PCOEF_W-1]) begin
            sat_add = sum[PCOEF_W] ? {1'b1, {(PCOEF_W-1){1'b0}}}
                                   : {1'b0, {(PCOEF_W-1){1'b1}}};
        end else begin
            sat_add = sum[PCOEF_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sparse_polynomial_multiply_unit.sv
// Load transfers (kind 0/1) are taken while idle; ready stays high there, so loads run back to back.
// Compute, per term pair: multiply, then scan the store (ASCAN reads an entry, ACMP compares
// it); a zero product is skipped, a match adds the product into that entry, else it is
// appended after the last entry. Each output term takes a selection scan over all N entries
// plus an output transfer (N = store entries, up to TERMS*TERMS). Not ready until the last one.
// Reset (aresetn low, synchronous) clears term counts and control; stores are not cleared.
`default_nettype none

module sparse_polynomial_multiply_unit
    import spm_pkg::*;
#(
    parameter int TERMS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] coefficient, [30:16] exponent
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // [35:0] product_coefficient, [51:36] product_exponent
    output logic             m_tlast
);

    localparam int CNT_W       = $clog2(TERMS + 1);
    localparam int IDX_W       = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int STORE_DEPTH = TERMS * TERMS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SCNT_W      = $clog2(STORE_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_ASCAN = 7'b0000100,
        ST_ACMP  = 7'b0001000,
        ST_OSCAN = 7'b0010000,
        ST_OCMP  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    term_t first_terms_reg  [TERMS];
    term_t second_terms_reg [TERMS];

    logic [CNT_W-1:0]   first_count_reg, first_count_next;
    logic [CNT_W-1:0]   second_count_reg, second_count_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PEXP_W-1:0]  pexp_reg, pexp_next;
    logic [SCNT_W-1:0]  n_reg, n_next;
    logic [SCNT_W-1:0]  k_reg, k_next;
    logic [SCNT_W-1:0]  total_reg, total_next;
    logic [SCNT_W-1:0]  emitted_reg, emitted_next;
    logic               found_reg, found_next;
    logic               bounded_reg, bounded_next;
    logic [PEXP_W-1:0]  bound_reg, bound_next;
    logic [PCOEF_W-1:0] best_coef_reg, best_coef_next;
    logic [PEXP_W-1:0]  best_exp_reg, best_exp_next;
    logic               last_reg, last_next;

    term_t             in_term;
    term_t             term_a;
    term_t             term_b;
    logic signed [COEF_W-1:0] mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic              load_first;
    logic              load_second;
    logic              advance;
    logic              start_out;
    logic              last_pair;
    logic              ram_we;
    entry_t            ram_wdata;
    entry_t            ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;

    assign in_term.coef = s_tdata[COEF_W-1:0];
    assign in_term.expo = s_tdata[COEF_W+EXP_W-1:COEF_W];

    assign term_a = first_terms_reg[i_reg];
    assign term_b = second_terms_reg[j_reg];
    assign mul_a  = term_a.coef;
    assign mul_b  = term_b.coef;
    assign mul_p  = mul_a * mul_b;

    assign last_pair = ((CNT_W'(i_reg) + 1'b1) == first_count_reg)
                    && ((CNT_W'(j_reg) + 1'b1) == second_count_reg);

    assign ram_rdata = entry_t'(ram_rbits);

    spm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (k_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (k_reg[ADDR_W-1:0]),
        .rdata (ram_rbits)
    );

    always_comb begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        prod_next         = prod_reg;
        pexp_next         = pexp_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        total_next        = total_reg;
        emitted_next      = emitted_reg;
        found_next        = found_reg;
        bounded_next      = bounded_reg;
        bound_next        = bound_reg;
        best_coef_next    = best_coef_reg;
        best_exp_next     = best_exp_reg;
        last_next         = last_reg;
        s_tready          = 1'b0;
        m_tvalid          = 1'b0;
        load_first        = 1'b0;
        load_second       = 1'b0;
        advance           = 1'b0;
        start_out         = 1'b0;
        ram_we            = 1'b0;
        ram_wdata.coef    = {{(PCOEF_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        ram_wdata.expo    = pexp_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (kind_t'(s_tuser))
                        KIND_FIRST: begin
                            if (first_count_reg < CNT_W'(TERMS)) begin
                                load_first       = 1'b1;
                                first_count_next = first_count_reg + 1'b1;
                            end
                        end
                        KIND_SECOND: begin
                            if (second_count_reg < CNT_W'(TERMS)) begin
                                load_second       = 1'b1;
                                second_count_next = second_count_reg + 1'b1;
                            end
                        end
                        KIND_COMPUTE: begin
                            n_next = '0;
                            if (first_count_reg == '0 || second_count_reg == '0) begin
                                start_out = 1'b1;
                            end else begin
                                i_next     = '0;
                                j_next     = '0;
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: begin
                prod_next  = mul_p;
                pexp_next  = {1'b0, term_a.expo} + {1'b0, term_b.expo};
                k_next     = '0;
                state_next = ST_ASCAN;
            end
            ST_ASCAN: begin
                if (prod_reg == '0) begin
                    advance = 1'b1;
                end else if (k_reg == n_reg) begin
                    // no entry with this exponent yet: append
                    ram_we  = 1'b1;
                    n_next  = n_reg + 1'b1;
                    advance = 1'b1;
                end else begin
                    state_next = ST_ACMP;
                end
            end
            ST_ACMP: begin
                if (ram_rdata.expo == pexp_reg) begin
                    ram_we         = 1'b1;
                    ram_wdata.coef = sat_add(ram_rdata.coef, prod_reg);
                    advance        = 1'b1;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_ASCAN;
                end
            end
            ST_OSCAN: begin
                if (k_reg == n_reg) begin
                    if (found_reg) begin
                        last_next = (emitted_reg + 1'b1) == total_reg;
                    end else begin
                        // every sum cancelled or nothing loaded
                        best_coef_next = '0;
                        best_exp_next  = '0;
                        last_next      = 1'b1;
                    end
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_OCMP;
                end
            end
            ST_OCMP: begin
                if (ram_rdata.coef != '0) begin
                    if (!bounded_reg) begin
                        total_next = total_reg + 1'b1;
                    end
                    if ((!bounded_reg || ram_rdata.expo < bound_reg)
                        && (!found_reg || ram_rdata.expo > best_exp_reg)) begin
                        found_next     = 1'b1;
                        best_coef_next = ram_rdata.coef;
                        best_exp_next  = ram_rdata.expo;
                    end
                end
                k_next     = k_reg + 1'b1;
                state_next = ST_OSCAN;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (last_reg) begin
                        first_count_next  = '0;
                        second_count_next = '0;
                        n_next            = '0;
                        state_next        = ST_IDLE;
                    end else begin
                        bound_next   = best_exp_reg;
                        bounded_next = 1'b1;
                        found_next   = 1'b0;
                        k_next       = '0;
                        emitted_next = emitted_reg + 1'b1;
                        state_next   = ST_OSCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance) begin
            if (last_pair) begin
                start_out = 1'b1;
            end else begin
                if ((CNT_W'(j_reg) + 1'b1) == second_count_reg) begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
                state_next = ST_MUL;
            end
        end

        if (start_out) begin
            k_next       = '0;
            total_next   = '0;
            emitted_next = '0;
            found_next   = 1'b0;
            bounded_next = 1'b0;
            state_next   = ST_OSCAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            n_reg            <= '0;
            k_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            total_reg        <= '0;
            emitted_reg      <= '0;
            found_reg        <= 1'b0;
            bounded_reg      <= 1'b0;
            last_reg         <= 1'b0;
        end else begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            n_reg            <= n_next;
            k_reg            <= k_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            total_reg        <= total_next;
            emitted_reg      <= emitted_next;
            found_reg        <= found_next;
            bounded_reg      <= bounded_next;
            last_reg         <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        pexp_reg      <= pexp_next;
        bound_reg     <= bound_next;
        best_coef_reg <= best_coef_next;
        best_exp_reg  <= best_exp_next;
        if (load_first) begin
            first_terms_reg[first_count_reg[IDX_W-1:0]] <= in_term;
        end
        if (load_second) begin
            second_terms_reg[second_count_reg[IDX_W-1:0]] <= in_term;
        end
    end

    assign m_tdata = {4'b0000, best_exp_reg, best_coef_reg};
    assign m_tlast = last_reg;

    // Store never holds more entries than there are term pairs.
    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= SCNT_W'(STORE_DEPTH))
        else $error("product store overfilled");

    // Loads stop at the configured term limit.
    a_term_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        first_count_reg <= CNT_W'(TERMS) && second_count_reg <= CNT_W'(TERMS))
        else $error("term count beyond limit");

    // After the first output, the emitted count stays below the count of terms found.
    a_emit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        bounded_reg |-> (emitted_reg < total_reg))
        else $error("more terms emitted than counted");

    // Input side stays closed while a result is offered.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted during output");

    // Finishing a product clears the job for the next one.
    a_job_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=>
            (first_count_reg == '0 && second_count_reg == '0 && n_reg == '0))
        else $error("job state not cleared after last term");

endmodule

`default_nettype wire

### hw/rtl/spm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spm_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
